// ----- hw/rtl/ntcm_pkg.sv -----
package ntcm_pkg;

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		CFG_FULL_SCALE = 3'd0,
		CFG_MAX_CODE   = 3'd1,
		CFG_SUPPLY     = 3'd2,
		CFG_FIXED_R    = 3'd3,
		CFG_NOMINAL_R  = 3'd4,
		CFG_REF_K      = 3'd5,
		CFG_BETA       = 3'd6
	} cfg_reg_t;

	// ln2 in Q0.32
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	// width of a logarithm argument and of an unsigned Q6.16 logarithm
	localparam int LN_XW = 33;
	localparam int LN_QW = 22;

	localparam int ZERO_C_MK  = 273150;
	localparam int T_MAX_MDEG = 600000;
	localparam int T_MIN_MDEG = -200000;
	localparam int MK_HI      = ZERO_C_MK + T_MAX_MDEG;
	localparam int MK_LO      = ZERO_C_MK + T_MIN_MDEG;

endpackage

// ----- hw/rtl/ntcm_div.sv -----
module ntcm_div #(
	parameter int N  = 8,
	parameter int D  = 8,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [N-1:0]  num,
	input  logic [D-1:0]  den,
	input  logic [SW-1:0] side_in,
	output logic [N-1:0]  quot,
	output logic [SW-1:0] side_out
);

	// one quotient bit per stage; w holds the remaining dividend bits on top
	// and the quotient bits produced so far at the bottom
	logic [N-1:0]  w_s    [N];
	logic [D-1:0]  rem_s  [N];
	logic [D-1:0]  den_s  [N];
	logic [SW-1:0] side_s [N];
	logic [N-1:0]  w_nx   [N];
	logic [D-1:0]  rem_nx [N];

	function automatic logic [N+D-1:0] step(input logic [N-1:0] w, input logic [D-1:0] r,
			input logic [D-1:0] d);
		logic [D:0] t;
		logic [D:0] s;
		logic       ge;
		t = {r, w[N-1]};
		s = t - {1'b0, d};
		ge = (t >= {1'b0, d});
		step = {w[N-2:0], ge, (ge ? s[D-1:0] : t[D-1:0])};
	endfunction

	always_comb begin
		{w_nx[0], rem_nx[0]} = step(num, '0, den);
		for (int i = 1; i < N; i++) begin
			{w_nx[i], rem_nx[i]} = step(w_s[i-1], rem_s[i-1], den_s[i-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den;
			for (int i = 0; i < N; i++) begin
				w_s[i]   <= w_nx[i];
				rem_s[i] <= rem_nx[i];
			end
			for (int i = 1; i < N; i++) begin
				den_s[i] <= den_s[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				side_s[i] <= '0;
			end
		end else if (en) begin
			side_s[0] <= side_in;
			for (int i = 1; i < N; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	assign quot     = w_s[N-1];
	assign side_out = side_s[N-1];

endmodule

// ----- hw/rtl/ntcm_ln.sv -----
module ntcm_ln import ntcm_pkg::*; #(
	parameter int ITER = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_in,
	input  logic [LN_XW-1:0]        x_a,
	input  logic [LN_XW-1:0]        x_b,
	output logic                    vld_out,
	output logic signed [LN_QW:0]   ratio
);

	// two lanes: ln(x_a) and ln(x_b), ratio = ln(x_a) - ln(x_b)
	logic [LN_XW-1:0] x_l1    [2];
	logic [5:0]       e_l1    [2];
	logic             vld_l1;
	logic [5:0]       e_c     [2];
	logic [30:0]      m_c     [2];

	logic [30:0]      m_s     [ITER+1][2];
	logic [5:0]       e_s     [ITER+1][2];
	logic [31:0]      frac_s  [ITER+1][2];
	logic             vld_s   [ITER+1];
	logic [61:0]      sq_c    [ITER][2];

	logic [37:0]      ea_c    [2];
	logic [63:0]      fb_c    [2];
	logic [37:0]      a_f1    [2];
	logic [31:0]      b_f1    [2];
	logic             vld_f1;
	logic [37:0]      sum_c   [2];
	logic signed [LN_QW:0] ratio_c;
	logic signed [LN_QW:0] ratio_f2;
	logic             vld_f2;

	function automatic logic [5:0] msb_index(input logic [LN_XW-1:0] x);
		logic [5:0] e;
		e = '0;
		for (int b = 0; b < LN_XW; b++) begin
			if (x[b]) e = 6'(b);
		end
		return e;
	endfunction

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			e_c[l] = msb_index(l == 0 ? x_a : x_b);
			// mantissa to Q30 in [1,2)
			if (e_l1[l] <= 6'd30) begin
				m_c[l] = 31'(x_l1[l] << (6'd30 - e_l1[l]));
			end else begin
				m_c[l] = 31'(x_l1[l] >> (e_l1[l] - 6'd30));
			end
		end
		for (int i = 0; i < ITER; i++) begin
			for (int l = 0; l < 2; l++) begin
				sq_c[i][l] = m_s[i][l] * m_s[i][l];
			end
		end
		for (int l = 0; l < 2; l++) begin
			ea_c[l]  = 38'(e_s[ITER][l]) * 38'(LN2_Q32);
			fb_c[l]  = 64'(frac_s[ITER][l]) * 64'(LN2_Q32);
			sum_c[l] = a_f1[l] + 38'(b_f1[l]);
		end
		ratio_c = $signed({1'b0, sum_c[0][37:16]}) - $signed({1'b0, sum_c[1][37:16]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_l1[0] <= x_a;
			x_l1[1] <= x_b;
			for (int l = 0; l < 2; l++) begin
				e_l1[l]      <= e_c[l];
				m_s[0][l]    <= m_c[l];
				e_s[0][l]    <= e_l1[l];
				frac_s[0][l] <= '0;
			end
			for (int i = 0; i < ITER; i++) begin
				for (int l = 0; l < 2; l++) begin
					e_s[i+1][l] <= e_s[i][l];
					// square >= 2: next fraction bit of log2 is one
					if (sq_c[i][l][61]) begin
						m_s[i+1][l]    <= sq_c[i][l][61:31];
						frac_s[i+1][l] <= frac_s[i][l] | (32'h8000_0000 >> i);
					end else begin
						m_s[i+1][l]    <= sq_c[i][l][60:30];
						frac_s[i+1][l] <= frac_s[i][l];
					end
				end
			end
			for (int l = 0; l < 2; l++) begin
				a_f1[l] <= ea_c[l];
				b_f1[l] <= fb_c[l][63:32];
			end
			ratio_f2 <= ratio_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_l1 <= 1'b0;
			for (int i = 0; i <= ITER; i++) begin
				vld_s[i] <= 1'b0;
			end
			vld_f1 <= 1'b0;
			vld_f2 <= 1'b0;
		end else if (en) begin
			vld_l1   <= vld_in;
			vld_s[0] <= vld_l1;
			for (int i = 0; i < ITER; i++) begin
				vld_s[i+1] <= vld_s[i];
			end
			vld_f1 <= vld_s[ITER];
			vld_f2 <= vld_f1;
		end
	end

	assign vld_out = vld_f2;
	assign ratio   = ratio_f2;

endmodule

// ----- hw/rtl/ntc_thermistor_to_millidegrees.sv -----
// NTC thermistor converter: ADC code in, temperature in millidegrees C out.
// Input channel: adc_code with in_valid/in_ready. Output channel:
// temperature_mdeg and saturated with out_valid/out_ready. One word per
// channel moves when valid and ready are both high.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write registers only while no word is in flight.
// The datapath is one stall-all pipeline: a word can enter every cycle while
// the output is not stalled. Its depth is set by four restoring dividers in
// series, one quotient bit per stage (28, 33, 47 and 50 stages), and by one
// squaring stage per bit of the logarithm.
// When the receiver holds out_ready low with a result waiting, every stage
// holds and in_ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the default register values.
module ntc_thermistor_to_millidegrees import ntcm_pkg::*; #(
	parameter int LN_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] adc_code,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [20:0] temperature_mdeg,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_data
);

	localparam logic [46:0] REF_NUM = 47'd1 << 40;
	localparam logic [49:0] MK_NUM  = 50'd1000 << 40;

	logic [12:0] full_scale_q;
	logic [14:0] max_code_q;
	logic [12:0] supply_q;
	logic [19:0] fixed_r_q;
	logic [19:0] nominal_q;
	logic [8:0]  ref_k_q;
	logic [13:0] beta_q;

	logic en;

	logic [14:0] code_c;
	logic [27:0] prod_s1;
	logic        vld_s1;
	logic [14:0] max_code_c;

	logic [27:0] v_q_d;
	logic        v_vld_d;
	logic [12:0] v_c;
	logic [12:0] diff_c;
	logic [12:0] v_s2;
	logic [12:0] diff_s2;
	logic        vld_s2;
	logic [32:0] rnum_s3;
	logic [12:0] v_s3;
	logic        vld_s3;

	logic [32:0] r_d;
	logic        r_vld_d;
	logic [LN_XW-1:0] x_r_c;
	logic [LN_XW-1:0] x_n_c;

	logic              ln_vld;
	logic signed [LN_QW:0] log_diff;
	logic [LN_QW:0]    mag_c;
	logic [46:0]       mag_s5;
	logic              neg_s5;
	logic              vld_s5;
	logic [13:0]       beta_c;
	logic [8:0]        ref_c;

	logic [46:0]       qb_d;
	logic              neg_d;
	logic [46:0]       qr_d;
	logic              inv_vld_d;
	logic signed [48:0] inv_c;
	logic [46:0]       inv_s6;
	logic              pos_s6;
	logic              vld_s6;

	logic [49:0]       mk_d;
	logic [1:0]        mk_side_d;
	logic signed [20:0] mdeg_c;
	logic              sat_c;
	logic signed [20:0] mdeg_s7;
	logic              sat_s7;
	logic              vld_s7;

	assign en        = !vld_s7 || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= 13'd4096;
			max_code_q   <= 15'd32767;
			supply_q     <= 13'd3300;
			fixed_r_q    <= 20'd10000;
			nominal_q    <= 20'd10000;
			ref_k_q      <= 9'd298;
			beta_q       <= 14'd3950;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_FULL_SCALE: full_scale_q <= cfg_data[12:0];
				CFG_MAX_CODE:   max_code_q   <= cfg_data[14:0];
				CFG_SUPPLY:     supply_q     <= cfg_data[12:0];
				CFG_FIXED_R:    fixed_r_q    <= cfg_data;
				CFG_NOMINAL_R:  nominal_q    <= cfg_data;
				CFG_REF_K:      ref_k_q      <= cfg_data[8:0];
				CFG_BETA:       beta_q       <= cfg_data[13:0];
				default: begin
				end
			endcase
		end
	end

	// stage 1: non-positive codes become 1, scale by full scale
	assign code_c     = (adc_code == 16'sd0 || adc_code[15]) ? 15'd1 : adc_code[14:0];
	assign max_code_c = (max_code_q == '0) ? 15'd1 : max_code_q;

	always_ff @(posedge clk) begin
		if (en) prod_s1 <= code_c * full_scale_q;
	end

	ntcm_div #(.N(28), .D(15), .SW(1)) u_div_v (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(prod_s1), .den(max_code_c), .side_in(vld_s1),
		.quot(v_q_d), .side_out(v_vld_d)
	);

	// stage 2: keep the voltage between 1 mV and one below the supply
	always_comb begin
		if (v_q_d >= 28'(supply_q)) begin
			v_c = (supply_q == '0) ? 13'd0 : supply_q - 13'd1;
		end else begin
			v_c = v_q_d[12:0];
		end
		if (v_c == '0) v_c = 13'd1;
		diff_c = (supply_q > v_c) ? supply_q - v_c : 13'd0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s2    <= v_c;
			diff_s2 <= diff_c;
			rnum_s3 <= fixed_r_q * diff_s2;
			v_s3    <= v_s2;
		end
	end

	ntcm_div #(.N(33), .D(13), .SW(1)) u_div_r (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(rnum_s3), .den(v_s3), .side_in(vld_s3),
		.quot(r_d), .side_out(r_vld_d)
	);

	assign x_r_c = (r_d == '0) ? LN_XW'(1) : r_d;
	assign x_n_c = (nominal_q == '0) ? LN_XW'(1) : LN_XW'(nominal_q);

	ntcm_ln #(.ITER(LN_ITERATIONS)) u_ln (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(r_vld_d),
		.x_a(x_r_c), .x_b(x_n_c),
		.vld_out(ln_vld), .ratio(log_diff)
	);

	// stage 5: ln ratio * 2^24 as sign and magnitude, so the divide truncates toward zero
	assign mag_c  = log_diff[LN_QW] ? (LN_QW+1)'(1) + ~log_diff : log_diff;
	assign beta_c = (beta_q == '0) ? 14'd1 : beta_q;
	assign ref_c  = (ref_k_q == '0) ? 9'd1 : ref_k_q;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5 <= {mag_c, 24'd0};
			neg_s5 <= log_diff[LN_QW];
		end
	end

	ntcm_div #(.N(47), .D(14), .SW(1)) u_div_beta (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(mag_s5), .den(beta_c), .side_in(neg_s5),
		.quot(qb_d), .side_out(neg_d)
	);

	ntcm_div #(.N(47), .D(9), .SW(1)) u_div_ref (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(REF_NUM), .den(ref_c), .side_in(vld_s5),
		.quot(qr_d), .side_out(inv_vld_d)
	);

	// stage 6: inverse temperature in Q40
	assign inv_c = $signed({2'b00, qr_d}) +
		(neg_d ? -$signed({2'b00, qb_d}) : $signed({2'b00, qb_d}));

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s6 <= !inv_c[48] && (inv_c != '0);
			inv_s6 <= (!inv_c[48] && (inv_c != '0)) ? inv_c[46:0] : 47'd1;
		end
	end

	ntcm_div #(.N(50), .D(47), .SW(2)) u_div_mk (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(MK_NUM), .den(inv_s6), .side_in({vld_s6, pos_s6}),
		.quot(mk_d), .side_out(mk_side_d)
	);

	// stage 7: to Celsius with saturation
	always_comb begin
		mdeg_c = 21'($signed({2'b00, mk_d[19:0]}) - 22'(ZERO_C_MK));
		sat_c  = 1'b0;
		if (!mk_side_d[0]) begin
			// non-positive inverse: unboundedly hot
			mdeg_c = 21'(T_MAX_MDEG);
			sat_c  = 1'b1;
		end else if (mk_d > 50'(MK_HI)) begin
			mdeg_c = 21'(T_MAX_MDEG);
			sat_c  = 1'b1;
		end else if (mk_d < 50'(MK_LO)) begin
			mdeg_c = 21'(T_MIN_MDEG);
			sat_c  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mdeg_s7 <= mdeg_c;
			sat_s7  <= sat_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= v_vld_d;
			vld_s3 <= vld_s2;
			vld_s5 <= ln_vld;
			vld_s6 <= inv_vld_d;
			vld_s7 <= mk_side_d[1];
		end
	end

	assign out_valid        = vld_s7;
	assign temperature_mdeg = mdeg_s7;
	assign saturated        = sat_s7;

endmodule
